// ===== design/ppl_pkg.sv =====
package ppl_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] CFG_KP   = 3'd0;
  localparam logic [2:0] CFG_KI   = 3'd1;
  localparam logic [2:0] CFG_SCL  = 3'd2;
  localparam logic [2:0] CFG_VCUT = 3'd3;
  localparam logic [2:0] CFG_OCUT = 3'd4;
  localparam logic [2:0] CFG_KF   = 3'd5;
  localparam logic [2:0] CFG_MASS = 3'd6;
  localparam logic [2:0] CFG_RAMP = 3'd7;
  localparam int unsigned CFG_NUM = 8;

  localparam logic [31:0] CFG_RESET [CFG_NUM] = '{
    32'd131072000, 32'd9830400, 32'd3928, 32'd19660800,
    32'd13107200, 32'd3080192, 32'd184615, 32'd4294967
  };

  localparam logic signed [47:0] POS_VEL_K = 48'sd1407374884;
  localparam logic signed [47:0] POS_ERR_K = 48'sd281474977;
  localparam logic signed [47:0] ONE_Q     = 48'sd1;
  localparam logic signed [16:0] CUR_LIMIT = 17'sd45875;
  localparam logic signed [38:0] DAC_OFFSET = 39'sd51538821120;
  localparam logic signed [21:0] DAC_SLOPE  = 22'sd1310700;
  // ceil(2^19 / 3): floor(x / 3) for x below 2^19
  localparam logic [17:0] RECIP3 = 18'd174763;
  localparam logic [19:0] US_PER_S  = 20'd1000000;
  localparam logic [19:0] US_HALF   = 20'd500000;

  localparam logic signed [47:0] SAT_POS = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] SAT_NEG = {1'b1, {47{1'b0}}};

  typedef enum logic [1:0] {SH_0, SH_8, SH_16, SH_32} shift_t;

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_ROUND} mul_state_t;

  typedef enum logic [4:0] {
    S_IDLE, S_REF, S_DIV, S_POS, S_VI, S_VE, S_DOB1, S_DOB2, S_FIN,
    S_OF1, S_OF2, S_FO, S_MEAS, S_EI, S_FP, S_FI, S_C1, S_C2, S_PE,
    S_DAC1, S_DAC2, S_OUT
  } ctl_state_t;

  typedef struct packed {
    logic             start;
    logic signed [47:0] a;
    logic signed [47:0] b;
    shift_t           sh;
  } mul_req_t;

  function automatic logic signed [47:0] add_sat(input logic signed [47:0] x,
                                                 input logic signed [47:0] y);
    logic signed [48:0] s;
    s = 49'(x) + 49'(y);
    if (s > 49'(SAT_POS)) return SAT_POS;
    else if (s < 49'(SAT_NEG)) return SAT_NEG;
    else return s[47:0];
  endfunction

  function automatic logic signed [47:0] sub_sat(input logic signed [47:0] x,
                                                 input logic signed [47:0] y);
    logic signed [48:0] s;
    s = 49'(x) - 49'(y);
    if (s > 49'(SAT_POS)) return SAT_POS;
    else if (s < 49'(SAT_NEG)) return SAT_NEG;
    else return s[47:0];
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [47:0] x);
    if (x > 48'sh0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    else if (x < -48'sh0000_8000_0000) return 32'sh8000_0000;
    else return x[31:0];
  endfunction

endpackage

// ===== design/ppl_mul.sv =====
module ppl_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  ppl_pkg::mul_req_t  req,
  output logic               done,
  output logic signed [47:0] prod
);

  ppl_pkg::mul_state_t st_r, st_nxt;
  logic [47:0] ua_r, ub_r, hi_r, lo_r;
  logic        neg_r;
  ppl_pkg::shift_t sh_r;
  logic [3:0]  cnt_r;
  logic        done_r;
  logic signed [47:0] prod_r;

  logic [51:0] pp;
  logic [52:0] sum;
  logic [96:0] full, rnd, shd;
  logic [47:0] mag, limit;
  logic        over;

  // one radix-16 digit of the multiplier a cycle
  assign pp  = ua_r * ub_r[3:0];
  assign sum = {5'd0, hi_r} + {1'b0, pp};

  always_comb begin
    full = {1'b0, hi_r, lo_r};
    unique case (sh_r)
      ppl_pkg::SH_0:  begin rnd = full;                 shd = rnd;       end
      ppl_pkg::SH_8:  begin rnd = full + 97'd128;       shd = rnd >> 8;  end
      ppl_pkg::SH_16: begin rnd = full + 97'd32768;     shd = rnd >> 16; end
      ppl_pkg::SH_32: begin rnd = full + 97'h8000_0000; shd = rnd >> 32; end
      default:        begin rnd = full;                 shd = rnd;       end
    endcase
    over  = |shd[96:48];
    limit = neg_r ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    mag   = (over || shd[47:0] > limit) ? limit : shd[47:0];
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ppl_pkg::M_IDLE:  if (req.start) st_nxt = ppl_pkg::M_RUN;
      ppl_pkg::M_RUN:   if (cnt_r == 4'd1) st_nxt = ppl_pkg::M_ROUND;
      ppl_pkg::M_ROUND: st_nxt = ppl_pkg::M_IDLE;
      default:          st_nxt = ppl_pkg::M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ppl_pkg::M_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == ppl_pkg::M_ROUND);
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      ppl_pkg::M_IDLE: begin
        ua_r  <= req.a[47] ? 48'(-req.a) : req.a;
        ub_r  <= req.b[47] ? 48'(-req.b) : req.b;
        neg_r <= req.a[47] ^ req.b[47];
        sh_r  <= req.sh;
        hi_r  <= '0;
        lo_r  <= '0;
        cnt_r <= 4'd12;
      end
      ppl_pkg::M_RUN: begin
        hi_r  <= sum[51:4];
        lo_r  <= {sum[3:0], lo_r[47:4]};
        ub_r  <= ub_r >> 4;
        cnt_r <= cnt_r - 4'd1;
      end
      ppl_pkg::M_ROUND: prod_r <= neg_r ? -$signed(mag) : $signed(mag);
      default: ;
    endcase
  end

  assign done = done_r;
  assign prod = prod_r;

endmodule

// ===== design/ppl_div.sv =====
module ppl_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] diff,
  output logic        done,
  output logic [47:0] quo
);

  logic [63:0] num_r;
  logic [19:0] rem_r;
  logic [47:0] quo_r;
  logic [6:0]  cnt_r;
  logic        busy_r, done_r;
  logic [20:0] rem2;
  logic        qbit;

  // restoring division by one million, one quotient bit a cycle
  assign rem2 = {rem_r, num_r[63]};
  assign qbit = rem2 >= 21'(ppl_pkg::US_PER_S);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && cnt_r == 7'd1;
      if (start) busy_r <= 1'b1;
      else if (busy_r && cnt_r == 7'd1) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= {diff, 32'd0} + 64'(ppl_pkg::US_HALF);
      rem_r <= '0;
      cnt_r <= 7'd64;
    end else if (busy_r) begin
      num_r <= num_r << 1;
      rem_r <= qbit ? 20'(rem2 - 21'(ppl_pkg::US_PER_S)) : rem2[19:0];
      quo_r <= {quo_r[46:0], qbit};
      cnt_r <= cnt_r - 7'd1;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== design/position_pi_loop_with_observer.sv =====
// Channel   Direction  Handshake              Word
// in_       input      in_valid / in_ready    encoder_count, sample_time_us
// out_      output     out_valid / out_ready  dac_code, current_command,
//                                             observed_force, position_error
// cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each word takes 17 products through a shared radix-16 multiplier, a bit-serial
// period divider, and the steps to accept, map the DAC code and hand off.
// rst_n is synchronous; it loads the register defaults and clears the control and loop state.
// A finished result waits in the output register while the next word is taken;
// the sequencer stalls at its last step only if that register is still full.
module position_pi_loop_with_observer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_encoder_count,
  input  logic [31:0]        in_sample_time_us,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_dac_code,
  output logic signed [16:0] out_current_command,
  output logic signed [31:0] out_observed_force,
  output logic signed [31:0] out_position_error,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  ppl_pkg::ctl_state_t st_r, st_nxt;
  logic [31:0] cfg_r [ppl_pkg::CFG_NUM];

  logic [31:0] last_time_r, prior_time_r, last_count_r;
  logic signed [47:0] sp_r, vint_r, vest_r, ref_r, eint_r, of_r;
  logic signed [16:0] pcur_r;
  logic signed [31:0] count_r;
  logic [31:0] now_r;
  logic signed [47:0] tmp_r, dob_r, err_r;
  logic signed [31:0] fo_r, pe_r;
  logic signed [16:0] cur_r;
  logic signed [38:0] dac_n_r;
  logic [15:0] code_r;
  logic run_r, out_valid_r;
  logic [15:0] o_code_r;
  logic signed [16:0] o_cur_r;
  logic signed [31:0] o_fo_r, o_pe_r;

  ppl_pkg::mul_req_t mreq;
  logic mul_done, div_done, div_start, use_mul, out_fire;
  logic signed [47:0] mprod;
  logic [47:0] div_q;
  logic signed [48:0] neg_m;
  logic signed [38:0] dac_prod;
  logic [36:0] dac_q;

  ppl_mul u_mul (.clk, .rst_n, .req(mreq), .done(mul_done), .prod(mprod));

  ppl_div u_div (.clk, .rst_n, .start(div_start), .diff(last_time_r - prior_time_r),
                 .done(div_done), .quo(div_q));

  assign in_ready  = (st_r == ppl_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_fire  = (st_r == ppl_pkg::S_OUT) && (!out_valid_r || out_ready);
  assign div_start = (st_r == ppl_pkg::S_DIV) && !run_r;

  assign neg_m    = -{mprod[47], mprod};
  assign dac_prod = 39'(cur_r) * 39'(ppl_pkg::DAC_SLOPE);
  assign dac_q    = 37'(dac_n_r[37:19]) * 37'(ppl_pkg::RECIP3);

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ppl_pkg::S_IDLE: if (in_valid) st_nxt = ppl_pkg::S_REF;
      ppl_pkg::S_REF:  if (mul_done) st_nxt = ppl_pkg::S_DIV;
      ppl_pkg::S_DIV:  if (div_done) st_nxt = ppl_pkg::S_POS;
      ppl_pkg::S_POS:  if (mul_done) st_nxt = ppl_pkg::S_VI;
      ppl_pkg::S_VI:   if (mul_done) st_nxt = ppl_pkg::S_VE;
      ppl_pkg::S_VE:   if (mul_done) st_nxt = ppl_pkg::S_DOB1;
      ppl_pkg::S_DOB1: if (mul_done) st_nxt = ppl_pkg::S_DOB2;
      ppl_pkg::S_DOB2: if (mul_done) st_nxt = ppl_pkg::S_FIN;
      ppl_pkg::S_FIN:  if (mul_done) st_nxt = ppl_pkg::S_OF1;
      ppl_pkg::S_OF1:  if (mul_done) st_nxt = ppl_pkg::S_OF2;
      ppl_pkg::S_OF2:  if (mul_done) st_nxt = ppl_pkg::S_FO;
      ppl_pkg::S_FO:   if (mul_done) st_nxt = ppl_pkg::S_MEAS;
      ppl_pkg::S_MEAS: if (mul_done) st_nxt = ppl_pkg::S_EI;
      ppl_pkg::S_EI:   if (mul_done) st_nxt = ppl_pkg::S_FP;
      ppl_pkg::S_FP:   if (mul_done) st_nxt = ppl_pkg::S_FI;
      ppl_pkg::S_FI:   if (mul_done) st_nxt = ppl_pkg::S_C1;
      ppl_pkg::S_C1:   if (mul_done) st_nxt = ppl_pkg::S_C2;
      ppl_pkg::S_C2:   if (mul_done) st_nxt = ppl_pkg::S_PE;
      ppl_pkg::S_PE:   if (mul_done) st_nxt = ppl_pkg::S_DAC1;
      ppl_pkg::S_DAC1: st_nxt = ppl_pkg::S_DAC2;
      ppl_pkg::S_DAC2: st_nxt = ppl_pkg::S_OUT;
      ppl_pkg::S_OUT:  if (out_fire) st_nxt = ppl_pkg::S_IDLE;
      default:         st_nxt = ppl_pkg::S_IDLE;
    endcase
  end

  // multiplier operands for each step
  always_comb begin
    use_mul = 1'b1;
    mreq.a  = '0;
    mreq.b  = '0;
    mreq.sh = ppl_pkg::SH_0;
    unique case (st_r)
      ppl_pkg::S_REF: begin
        mreq.a = {16'd0, cfg_r[ppl_pkg::CFG_RAMP]}; mreq.b = sp_r; mreq.sh = ppl_pkg::SH_32;
      end
      ppl_pkg::S_POS: begin
        mreq.a = {{16{last_count_r[31]}}, last_count_r}; mreq.b = ppl_pkg::POS_VEL_K;
        mreq.sh = ppl_pkg::SH_16;
      end
      ppl_pkg::S_VI: begin
        mreq.a = vest_r; mreq.b = sp_r; mreq.sh = ppl_pkg::SH_32;
      end
      ppl_pkg::S_VE: begin
        mreq.a = {16'd0, cfg_r[ppl_pkg::CFG_VCUT]}; mreq.b = ppl_pkg::sub_sat(tmp_r, vint_r);
        mreq.sh = ppl_pkg::SH_16;
      end
      ppl_pkg::S_DOB1: begin
        mreq.a = vest_r; mreq.b = {16'd0, cfg_r[ppl_pkg::CFG_OCUT]}; mreq.sh = ppl_pkg::SH_16;
      end
      ppl_pkg::S_DOB2: begin
        mreq.a = tmp_r; mreq.b = {16'd0, cfg_r[ppl_pkg::CFG_MASS]}; mreq.sh = ppl_pkg::SH_16;
      end
      ppl_pkg::S_FIN: begin
        mreq.a = {16'd0, cfg_r[ppl_pkg::CFG_KF]}; mreq.b = {{31{pcur_r[16]}}, pcur_r};
        mreq.sh = ppl_pkg::SH_0;
      end
      ppl_pkg::S_OF1: begin
        mreq.a = {16'd0, cfg_r[ppl_pkg::CFG_OCUT]}; mreq.b = ppl_pkg::sub_sat(tmp_r, of_r);
        mreq.sh = ppl_pkg::SH_16;
      end
      ppl_pkg::S_OF2: begin
        mreq.a = tmp_r; mreq.b = sp_r; mreq.sh = ppl_pkg::SH_32;
      end
      ppl_pkg::S_FO: begin
        mreq.a = ppl_pkg::sub_sat(of_r, dob_r); mreq.b = ppl_pkg::ONE_Q; mreq.sh = ppl_pkg::SH_16;
      end
      ppl_pkg::S_MEAS: begin
        mreq.a = {{16{count_r[31]}}, count_r}; mreq.b = ppl_pkg::POS_ERR_K;
        mreq.sh = ppl_pkg::SH_16;
      end
      ppl_pkg::S_EI: begin
        mreq.a = err_r; mreq.b = sp_r; mreq.sh = ppl_pkg::SH_32;
      end
      ppl_pkg::S_FP: begin
        mreq.a = {16'd0, cfg_r[ppl_pkg::CFG_KP]}; mreq.b = err_r; mreq.sh = ppl_pkg::SH_16;
      end
      ppl_pkg::S_FI: begin
        mreq.a = {16'd0, cfg_r[ppl_pkg::CFG_KI]}; mreq.b = eint_r; mreq.sh = ppl_pkg::SH_16;
      end
      ppl_pkg::S_C1: begin
        mreq.a = tmp_r; mreq.b = {16'd0, cfg_r[ppl_pkg::CFG_SCL]}; mreq.sh = ppl_pkg::SH_16;
      end
      ppl_pkg::S_C2: begin
        mreq.a = tmp_r; mreq.b = ppl_pkg::ONE_Q; mreq.sh = ppl_pkg::SH_16;
      end
      ppl_pkg::S_PE: begin
        mreq.a = err_r; mreq.b = ppl_pkg::ONE_Q; mreq.sh = ppl_pkg::SH_8;
      end
      default: use_mul = 1'b0;
    endcase
    mreq.start = use_mul && !run_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ppl_pkg::S_IDLE;
      run_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < ppl_pkg::CFG_NUM; i++) cfg_r[i] <= ppl_pkg::CFG_RESET[i];
      last_time_r  <= '0;
      prior_time_r <= '0;
      last_count_r <= '0;
      sp_r         <= '0;
      vint_r       <= '0;
      vest_r       <= '0;
      ref_r        <= '0;
      eint_r       <= '0;
      of_r         <= '0;
      pcur_r       <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid) cfg_r[cfg_index] <= cfg_data;
      if (mreq.start || div_start) run_r <= 1'b1;
      else if (mul_done || div_done) run_r <= 1'b0;
      if (out_fire) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      unique case (st_r)
        ppl_pkg::S_REF: if (mul_done) ref_r <= ppl_pkg::add_sat(ref_r, mprod);
        ppl_pkg::S_DIV: if (div_done) begin
          sp_r         <= div_q;
          prior_time_r <= last_time_r;
        end
        ppl_pkg::S_VI:  if (mul_done) vint_r <= ppl_pkg::add_sat(vint_r, mprod);
        ppl_pkg::S_VE:  if (mul_done) vest_r <= mprod;
        ppl_pkg::S_OF2: if (mul_done) of_r <= ppl_pkg::add_sat(of_r, mprod);
        ppl_pkg::S_EI:  if (mul_done) eint_r <= ppl_pkg::add_sat(eint_r, mprod);
        ppl_pkg::S_C2:  if (mul_done) pcur_r <= (neg_m > 49'(ppl_pkg::CUR_LIMIT)) ?
                                                ppl_pkg::CUR_LIMIT :
                                                (neg_m < -49'(ppl_pkg::CUR_LIMIT)) ?
                                                -ppl_pkg::CUR_LIMIT : neg_m[16:0];
        ppl_pkg::S_OUT: if (out_fire) begin
          last_time_r  <= now_r;
          last_count_r <= count_r;
        end
        default: ;
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      count_r <= in_encoder_count;
      now_r   <= in_sample_time_us;
    end
    unique case (st_r)
      ppl_pkg::S_POS, ppl_pkg::S_DOB1, ppl_pkg::S_OF1, ppl_pkg::S_FP, ppl_pkg::S_C1:
        if (mul_done) tmp_r <= mprod;
      ppl_pkg::S_DOB2: if (mul_done) dob_r <= mprod;
      ppl_pkg::S_FIN:  if (mul_done) tmp_r <= ppl_pkg::add_sat(mprod, dob_r);
      ppl_pkg::S_FO:   if (mul_done) fo_r <= ppl_pkg::clamp32(mprod);
      ppl_pkg::S_MEAS: if (mul_done) err_r <= ppl_pkg::sub_sat(ref_r, mprod);
      ppl_pkg::S_FI:   if (mul_done) tmp_r <= ppl_pkg::add_sat(tmp_r, mprod);
      ppl_pkg::S_C2:   if (mul_done) cur_r <= (neg_m > 49'(ppl_pkg::CUR_LIMIT)) ?
                                              ppl_pkg::CUR_LIMIT :
                                              (neg_m < -49'(ppl_pkg::CUR_LIMIT)) ?
                                              -ppl_pkg::CUR_LIMIT : neg_m[16:0];
      ppl_pkg::S_PE:   if (mul_done) pe_r <= ppl_pkg::clamp32(mprod);
      ppl_pkg::S_DAC1: dac_n_r <= ppl_pkg::DAC_OFFSET + dac_prod;
      ppl_pkg::S_DAC2: begin
        // negative drive saturates low; divide by 3 * 2^19 otherwise, saturating high at 16'hFFFF
        if (dac_n_r[38]) code_r <= '0;
        else if (dac_q[36:19] > 18'd65535) code_r <= 16'hFFFF;
        else code_r <= dac_q[34:19];
      end
      default: ;
    endcase
    if (out_fire) begin
      o_code_r <= code_r;
      o_cur_r  <= cur_r;
      o_fo_r   <= fo_r;
      o_pe_r   <= pe_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_dac_code        = o_code_r;
  assign out_current_command = o_cur_r;
  assign out_observed_force  = o_fo_r;
  assign out_position_error  = o_pe_r;

endmodule

// ===== bench/position_pi_loop_with_observer_tb.sv =====
`timescale 1ns / 100ps

module position_pi_loop_with_observer_tb;

  localparam int  STALL_LIMIT = 20000;
  localparam int  DRAIN_WAIT  = 400;
  localparam int  LONG_HOLD   = 3000;
  localparam longint DAC_STEP = 1572864;

  typedef struct packed {
    logic [15:0]        dac;
    logic signed [16:0] cur;
    logic signed [31:0] force_est;
    logic signed [31:0] pos_err;
  } loop_word_t;

  typedef struct {
    logic signed [31:0] count;
    logic [31:0]        stamp;
    bit                 typed;
    loop_word_t         word;
  } vector_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_encoder_count = '0;
  logic [31:0]        in_sample_time_us = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [15:0]        out_dac_code;
  logic signed [16:0] out_current_command;
  logic signed [31:0] out_observed_force;
  logic signed [31:0] out_position_error;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  position_pi_loop_with_observer DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // controller copy: registers and loop state, 48-bit values held in longint
  logic [31:0] gain_reg [ppl_pkg::CFG_NUM];
  logic [31:0] t_last, t_prior, cnt_last;
  longint      period, vel_int, vel_est, ref_pos, err_int, obs_filt, cur_prev;

  loop_word_t  expected_words[$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          use_typed = 0;
  loop_word_t  typed_word;
  bit          hold_request = 0;
  logic signed [31:0] next_count = '0;
  logic [31:0]        next_stamp = '0;
  int          burst_left = 0;

  function automatic longint sat48(input longint v);
    if (v > longint'(ppl_pkg::SAT_POS)) return longint'(ppl_pkg::SAT_POS);
    if (v < longint'(ppl_pkg::SAT_NEG)) return longint'(ppl_pkg::SAT_NEG);
    return v;
  endfunction

  function automatic longint lim32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // exact product, shift right with round half away from zero, saturate to 48 bits
  function automatic longint fx_mul(input longint a, input longint b, input int sh);
    logic [127:0] ua, ub, p, lim;
    bit neg;
    neg = (a < 0) != (b < 0);
    ua = {64'd0, (a < 0) ? -a : a};
    ub = {64'd0, (b < 0) ? -b : b};
    p = ua * ub;
    if (sh > 0) p = p + (128'd1 << (sh - 1));
    p = p >> sh;
    lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 1);
    if (p > lim) p = lim;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint reg_val(input int i);
    return longint'({32'd0, gain_reg[i]});
  endfunction

  function automatic void clear_loop();
    t_last = '0; t_prior = '0; cnt_last = '0;
    period = 0; vel_int = 0; vel_est = 0; ref_pos = 0;
    err_int = 0; obs_filt = 0; cur_prev = 0;
    for (int i = 0; i < ppl_pkg::CFG_NUM; i++) gain_reg[i] = ppl_pkg::CFG_RESET[i];
  endfunction

  function automatic loop_word_t step_loop(input logic signed [31:0] cnt,
                                          input logic [31:0] now);
    logic [31:0] d32;
    logic [63:0] q, r;
    longint      pos, dob, fin, fobs, meas, err, frc, cur, n, code, perr;
    loop_word_t  w;
    ref_pos = sat48(ref_pos + fx_mul(reg_val(ppl_pkg::CFG_RAMP), period, 32));
    d32 = t_last - t_prior;
    q = {32'd0, d32} / 64'd1000000;
    r = {32'd0, d32} % 64'd1000000;
    period = longint'((q << 32) + ((r << 32) + 64'd500000) / 64'd1000000);
    t_prior = t_last;
    // velocity filter runs on the previous word
    pos = fx_mul(longint'($signed(cnt_last)), longint'(ppl_pkg::POS_VEL_K), 16);
    vel_int = sat48(vel_int + fx_mul(vel_est, period, 32));
    vel_est = fx_mul(reg_val(ppl_pkg::CFG_VCUT), sat48(pos - vel_int), 16);
    dob = fx_mul(fx_mul(vel_est, reg_val(ppl_pkg::CFG_OCUT), 16),
                 reg_val(ppl_pkg::CFG_MASS), 16);
    fin = sat48(fx_mul(reg_val(ppl_pkg::CFG_KF), cur_prev, 0) + dob);
    obs_filt = sat48(obs_filt + fx_mul(fx_mul(reg_val(ppl_pkg::CFG_OCUT),
                     sat48(fin - obs_filt), 16), period, 32));
    fobs = lim32(fx_mul(sat48(obs_filt - dob), 1, 16));
    meas = fx_mul(longint'(cnt), longint'(ppl_pkg::POS_ERR_K), 16);
    err = sat48(ref_pos - meas);
    err_int = sat48(err_int + fx_mul(err, period, 32));
    frc = sat48(fx_mul(reg_val(ppl_pkg::CFG_KP), err, 16) +
                fx_mul(reg_val(ppl_pkg::CFG_KI), err_int, 16));
    cur = -fx_mul(fx_mul(frc, reg_val(ppl_pkg::CFG_SCL), 16), 1, 16);
    if (cur > longint'(ppl_pkg::CUR_LIMIT)) cur = longint'(ppl_pkg::CUR_LIMIT);
    if (cur < -longint'(ppl_pkg::CUR_LIMIT)) cur = -longint'(ppl_pkg::CUR_LIMIT);
    cur_prev = cur;
    n = longint'(ppl_pkg::DAC_OFFSET) + cur * longint'(ppl_pkg::DAC_SLOPE);
    code = (n < 0) ? 0 : n / DAC_STEP;
    if (code > 65535) code = 65535;
    t_last = now;
    cnt_last = cnt;
    perr = lim32(fx_mul(err, 1, 8));
    w.dac = code[15:0];
    w.cur = cur[16:0];
    w.force_est = fobs[31:0];
    w.pos_err = perr[31:0];
    return w;
  endfunction

  // track accepted words, register writes and results
  always @(posedge clk) begin
    loop_word_t w, got;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) gain_reg[cfg_index] = cfg_data;
      if (in_valid && in_ready) begin
        w = step_loop(in_encoder_count, in_sample_time_us);
        expected_words.push_back(use_typed ? typed_word : w);
      end
      if (out_valid && out_ready) begin
        got = '{out_dac_code, out_current_command, out_observed_force, out_position_error};
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected word dac=%0d cur=%0d", $time, got.dac, got.cur);
        end else begin
          w = expected_words.pop_front();
          if (got.dac !== w.dac) begin
            errors++;
            $display("%0t: dac_code exp %0d got %0d", $time, w.dac, got.dac);
          end
          if (got.cur !== w.cur) begin
            errors++;
            $display("%0t: current_command exp %0d got %0d", $time, w.cur, got.cur);
          end
          if (got.force_est !== w.force_est) begin
            errors++;
            $display("%0t: observed_force exp %0d got %0d", $time, w.force_est,
                     got.force_est);
          end
          if (got.pos_err !== w.pos_err) begin
            errors++;
            $display("%0t: position_error exp %0d got %0d", $time, w.pos_err,
                     got.pos_err);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // receiver: random stall pattern, plain stretches, one long hold-off on request
  initial begin
    int mode;
    mode = 0;
    @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 0;
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= $urandom_range(0, 1);
      endcase
    end
  end

  task automatic send_word(input logic signed [31:0] cnt, input logic [31:0] stamp);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 400);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_encoder_count <= cnt;
    in_sample_time_us <= stamp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_words(input int num, input bit long_hold);
    logic signed [31:0] c;
    logic [31:0] t;
    int k;
    for (int i = 0; i < num; i++) begin
      k = $urandom_range(0, 99);
      if (k < 70) c = next_count + $signed($urandom_range(0, 400)) - 200;
      else if (k < 85) c = $urandom;
      else c = (k & 1) ? 32'sh7FFF_FFFF - $urandom_range(0, 50)
                       : 32'sh8000_0000 + $urandom_range(0, 50);
      k = $urandom_range(0, 99);
      if (k < 85) t = next_stamp + $urandom_range(1, 60);
      else if (k < 95) t = $urandom;
      else t = next_stamp;
      next_count = c;
      next_stamp = t;
      if (long_hold && i == num / 2) hold_request = 1;
      // pause the sender until the loop has emptied
      if (i == num / 4) drain();
      send_word(c, t);
    end
    drain();
  endtask

  vector_t directed[$];

  initial begin
    clear_loop();
    directed = '{
      '{32'sd0, 32'd0, 1'b1, '{16'd32767, 17'sd0, 32'sd0, 32'sd0}},
      '{32'sh7FFF_FFFF, 32'd20, 1'b1,
        '{16'd65535, 17'sd45875, 32'sd0, 32'sh8000_0000}},
      '{32'sh8000_0000, 32'd40, 1'b0, '0},
      '{32'sd0, 32'd60, 1'b0, '0},
      '{32'sd1, 32'd80, 1'b0, '0},
      '{-32'sd1, 32'd80, 1'b0, '0},
      '{32'sh5555_5555, 32'd100, 1'b0, '0},
      '{32'shAAAA_AAAA, 32'hFFFF_FFF0, 1'b0, '0},
      '{32'sd1000, 32'h0000_0010, 1'b0, '0},
      '{32'sd2000, 32'h8000_0010, 1'b0, '0},
      '{32'sd2000, 32'h8000_0024, 1'b0, '0},
      '{-32'sd3000, 32'h8000_0038, 1'b0, '0},
      '{32'sd0, 32'hFFFF_FFFF, 1'b0, '0},
      '{32'sd0, 32'h0000_0000, 1'b0, '0},
      '{32'sd7, 32'd20, 1'b0, '0}
    };
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      // update at the edge so the word accepted there keeps its own expectation
      use_typed <= directed[i].typed;
      typed_word <= directed[i].word;
      send_word(directed[i].count, directed[i].stamp);
    end
    drain();
    use_typed <= 1'b0;
    next_stamp = 32'd20;

    random_words(110, 1'b0);

    for (int i = 0; i < ppl_pkg::CFG_NUM; i++) write_reg(i[2:0], $urandom);
    random_words(80, 1'b1);

    for (int i = 0; i < ppl_pkg::CFG_NUM; i++) write_reg(i[2:0], 32'h0);
    random_words(60, 1'b0);

    for (int i = 0; i < ppl_pkg::CFG_NUM; i++) write_reg(i[2:0], 32'hFFFF_FFFF);
    random_words(60, 1'b0);

    // moderate gains near the defaults so the loop stays out of the clamps
    for (int i = 0; i < ppl_pkg::CFG_NUM; i++)
      write_reg(i[2:0], ppl_pkg::CFG_RESET[i] +
                        $urandom_range(0, ppl_pkg::CFG_RESET[i] / 2));
    random_words(120, 1'b0);

    for (int i = 0; i < ppl_pkg::CFG_NUM; i++) write_reg(i[2:0], ppl_pkg::CFG_RESET[i]);
    random_words(110, 1'b1);

    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
